/* design/tlv_stream_parser_defines.svh */
// assertion macros used by the checker file
`ifndef TLV_STREAM_PARSER_DEFINES_SVH
`define TLV_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TSP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsp check failed");

// next-cycle implication, disabled during reset
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsp check failed");

`endif

/* design/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg
// types and constants shared by the tlv stream parser modules
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int FIELD_W = 15;

   localparam logic [7:0] LONG_FORM_BIT = 8'h80;

   typedef enum logic [1:0] {
      PH_TAG   = 2'd0,
      PH_LEN1  = 2'd1,
      PH_LEN2  = 2'd2,
      PH_VALUE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TAG   = 2'd0,
      KIND_LEN1  = 2'd1,
      KIND_LEN2  = 2'd2,
      KIND_VALUE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             byte_kind;
      logic [7:0]           byte_echo;
      logic [7:0]           current_tag;
      logic [FIELD_W-1:0]   element_length;
      logic [FIELD_W-1:0]   value_index;
      logic                 element_done;
   } result_type;

endpackage

/* design/tsp_front.sv */
// ----------------------------------------------------------------------------
// tsp_front
// classifies each request byte, tracks tag, length and value position
// ----------------------------------------------------------------------------
module tsp_front #(
   parameter int LENGTH_BITS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          data_byte,
   output tsp_pkg::result_type result
);
   import tsp_pkg::*;

   localparam logic [15:0] LenMax = 16'((1 << LENGTH_BITS) - 1);

   phase_type               phase_ff, phase_in;
   logic [7:0]              tag_ff, tag_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   logic [LENGTH_BITS-1:0]  count_ff, count_in;

   logic                    long_form;
   logic [15:0]             raw_len;
   logic [15:0]             sat_len;
   logic                    len_zero;
   logic [LENGTH_BITS:0]    count_inc;
   logic                    last_value;

   // length assembly and saturation
   always_comb begin
      long_form = (data_byte & LONG_FORM_BIT) != 8'h00;
      case (phase_ff)
         PH_LEN1: begin
            if (long_form) begin
               raw_len = {1'b0, data_byte[6:0], 8'h00};
            end else begin
               raw_len = {8'h00, data_byte};
            end
         end
         PH_LEN2: raw_len = 16'(length_ff) + {8'h00, data_byte};
         default: raw_len = 16'h0000;
      endcase
      sat_len    = (raw_len > LenMax) ? LenMax : raw_len;
      len_zero   = (sat_len == 16'h0000);
      count_inc  = {1'b0, count_ff} + {{LENGTH_BITS{1'b0}}, 1'b1};
      last_value = count_inc >= {1'b0, length_ff};
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (push) begin
         case (phase_ff)
            PH_TAG:   phase_in = PH_LEN1;
            PH_LEN1: begin
               if (long_form) begin
                  phase_in = PH_LEN2;
               end else begin
                  phase_in = len_zero ? PH_TAG : PH_VALUE;
               end
            end
            PH_LEN2:  phase_in = len_zero ? PH_TAG : PH_VALUE;
            PH_VALUE: phase_in = last_value ? PH_TAG : PH_VALUE;
            default:  phase_in = PH_TAG;
         endcase
      end
   end

   // held fields and the result for this byte
   always_comb begin
      tag_in    = tag_ff;
      length_in = length_ff;
      count_in  = count_ff;
      result.byte_echo    = data_byte;
      result.value_index  = '0;
      result.element_done = 1'b0;
      case (phase_ff)
         PH_TAG: begin
            result.byte_kind = KIND_TAG;
            tag_in    = data_byte;
            length_in = '0;
            count_in  = '0;
         end
         PH_LEN1: begin
            result.byte_kind    = KIND_LEN1;
            length_in           = sat_len[LENGTH_BITS-1:0];
            count_in            = '0;
            result.element_done = !long_form && len_zero;
         end
         PH_LEN2: begin
            result.byte_kind    = KIND_LEN2;
            length_in           = sat_len[LENGTH_BITS-1:0];
            count_in            = '0;
            result.element_done = len_zero;
         end
         default: begin
            result.byte_kind    = KIND_VALUE;
            result.value_index  = FIELD_W'(count_ff);
            result.element_done = last_value;
            count_in            = last_value ? '0 : count_inc[LENGTH_BITS-1:0];
         end
      endcase
      result.current_tag    = tag_in;
      result.element_length = FIELD_W'(length_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         tag_ff    <= '0;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (push) begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/tsp_queue.sv */
// ----------------------------------------------------------------------------
// tsp_queue
// short fifo of classified results between the front and back stages
// ----------------------------------------------------------------------------
module tsp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tsp_pkg::result_type push_data,
   input  logic                pop,
   output tsp_pkg::result_type pop_data,
   output logic                full,
   output logic                empty
);
   import tsp_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   result_type          entries_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   // pointers wrap naturally, so DEPTH must be a power of two; the block does not enforce it
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/tsp_back.sv */
// ----------------------------------------------------------------------------
// tsp_back
// output register: drains the queue and holds a response until taken
// ----------------------------------------------------------------------------
module tsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  tsp_pkg::result_type queue_data,
   output logic                pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output tsp_pkg::result_type rsp_data
);
   import tsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // load when the register is empty or being emptied this cycle
   assign pop      = !queue_empty && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= queue_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* design/tlv_stream_parser.sv */
// ----------------------------------------------------------------------------
// tlv_stream_parser
// byte-serial tag-length-value parser, one response per request byte
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one stream byte per request, valid/ready handshake.
//   rsp_* returns one response per byte: its kind (tag, first or second
//   length byte, value byte), the byte itself, the element's tag and length,
//   the value position and an end-of-element flag.
//   short-form length bytes give 0..127; with the top bit set the low seven
//   bits and the next byte form a length, saturated to LENGTH_BITS bits.
//   a zero length ends the element on its length byte.
//   a byte accepted is stored in the queue, then loaded into the output register and shown on rsp_*.
//   throughput: one byte per cycle while the queue is not full, set by the registered parse
//   state update in the front stage.
//   a queue of QUEUE_DEPTH entries plus the output register absorb a
//   stalled receiver; req_ready drops only when the queue is full.
//   reset (synchronous) returns the parser to expecting a tag and empties
//   the queue and output register.
// ----------------------------------------------------------------------------
module tlv_stream_parser #(
   parameter int LENGTH_BITS = 15,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_byte_kind,
   output logic [7:0]  rsp_byte_echo,
   output logic [7:0]  rsp_current_tag,
   output logic [14:0] rsp_element_length,
   output logic [14:0] rsp_value_index,
   output logic        rsp_element_done
);
   import tsp_pkg::*;

   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_empty;
   result_type front_result;
   result_type queue_head;
   result_type out_result;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   tsp_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .result    (front_result)
   );

   tsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_result),
      .pop       (pop),
      .pop_data  (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   tsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_head),
      .pop         (pop),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (out_result)
   );

   assign rsp_byte_kind      = out_result.byte_kind;
   assign rsp_byte_echo      = out_result.byte_echo;
   assign rsp_current_tag    = out_result.current_tag;
   assign rsp_element_length = out_result.element_length;
   assign rsp_value_index    = out_result.value_index;
   assign rsp_element_done   = out_result.element_done;

endmodule

/* design/tsp_checker.sv */
// ----------------------------------------------------------------------------
// tsp_checker
// port-level checks on the tlv stream parser, bound to the top level
// ----------------------------------------------------------------------------
`include "tlv_stream_parser_defines.svh"

module tsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_byte_kind,
   input logic [7:0]  rsp_byte_echo,
   input logic [7:0]  rsp_current_tag,
   input logic [14:0] rsp_element_length,
   input logic [14:0] rsp_value_index,
   input logic        rsp_element_done
);
   import tsp_pkg::*;

   logic [48:0] rsp_payload;
   logic        rsp_is_tag;
   logic        rsp_is_long_len1;
   logic        rsp_is_value;
   logic        rsp_tag_clear;

   assign rsp_payload      = {rsp_byte_kind, rsp_byte_echo, rsp_current_tag,
                              rsp_element_length, rsp_value_index, rsp_element_done};
   assign rsp_is_tag       = rsp_valid && (rsp_byte_kind == KIND_TAG);
   assign rsp_is_long_len1 = rsp_valid && (rsp_byte_kind == KIND_LEN1) && rsp_byte_echo[7];
   assign rsp_is_value     = rsp_valid && (rsp_byte_kind == KIND_VALUE);
   assign rsp_tag_clear    = (rsp_element_length == 15'd0) && (rsp_value_index == 15'd0)
                             && !rsp_element_done;

   // a waiting request keeps its byte
   `TSP_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data_byte))

   // a stalled response keeps its payload
   `TSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // a tag byte starts a fresh element
   `TSP_ASSERT_SAME(a_tag_fresh, rsp_is_tag, rsp_tag_clear)

   // a long-form first length byte never ends an element
   `TSP_ASSERT_SAME(a_long_open, rsp_is_long_len1, !rsp_element_done)

   // value position stays inside the element's length
   `TSP_ASSERT_SAME(a_index_range, rsp_is_value, rsp_value_index < rsp_element_length)

endmodule

bind tlv_stream_parser tsp_checker u_tsp_checker (.*);
